FILE: sv/assert_macros.svh
// assertion helpers used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TTY_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TTY_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: sv/tty_pkg.sv
// ----------------------------------------------------------------------------
// tty_pkg
// types, codes and constants of the teletype reader and punch interface
// ----------------------------------------------------------------------------
`default_nettype none

package tty_pkg;

	localparam int COLUMNS_DEF = 80;

	localparam int DELAY_W = 16;
	localparam int TIMER_W = DELAY_W + 1;
	localparam int AC_W    = 12;
	localparam int KEY_W   = 9;
	localparam int CHAR_W  = 7;
	localparam int POS_W   = 7;

	localparam logic [DELAY_W-1:0] DELAY_RST = 16'd100;

	typedef enum logic [1:0] {
		CMD_READER = 2'd0,
		CMD_PUNCH  = 2'd1,
		CMD_KEY    = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PK_PRINT = 2'd0,
		PK_CR    = 2'd1,
		PK_LF    = 2'd2,
		PK_BS    = 2'd3
	} print_kind_t;

	// iot micro-op bit positions
	localparam int IOT_SKIP  = 0;
	localparam int IOT_CLEAR = 1;
	localparam int IOT_XFER  = 2;

	// reader translation and read marker
	localparam logic [KEY_W-1:0] RD_LF_IN   = 9'o012;
	localparam logic [KEY_W-1:0] RD_CR_OUT  = 9'o015;
	localparam logic [KEY_W-1:0] RD_ALT_IN  = 9'o527;
	localparam logic [KEY_W-1:0] RD_LF_OUT  = 9'o012;
	localparam logic [KEY_W-1:0] RD_MARK    = 9'o200;

	// punch control codes, full buffer compare
	localparam logic [AC_W-1:0] PC_CR = 12'o0215;
	localparam logic [AC_W-1:0] PC_LF = 12'o0212;
	localparam logic [AC_W-1:0] PC_BS = 12'o0377;

	typedef struct packed {
		logic                 skip;
		logic                 ac_written;
		logic [AC_W-1:0]      ac_out;
		logic                 print_valid;
		print_kind_t          print_kind;
		logic [CHAR_W-1:0]    print_char;
		logic [POS_W-1:0]     print_column;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/teletype_reader_punch_interface.sv
// ----------------------------------------------------------------------------
// teletype_reader_punch_interface
// an item passes the input register in tty_core, then the result register that drives out_valid
// throughput: one item per cycle without stalls, set by the single state update in tty_core
// reset: arst_n low clears flags, buffers, timer, column and both valid bits;
//   punch_delay returns to 100
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module teletype_reader_punch_interface #(
	parameter int COLUMNS = tty_pkg::COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    cmd,
	input  wire logic [2:0]                    iot_bits,
	input  wire logic [tty_pkg::AC_W-1:0]      ac_in,
	input  wire logic [tty_pkg::KEY_W-1:0]     key_code,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               skip,
	output logic                               ac_written,
	output logic [tty_pkg::AC_W-1:0]           ac_out,
	output logic                               print_valid,
	output logic [1:0]                         print_kind,
	output logic [tty_pkg::CHAR_W-1:0]         print_char,
	output logic [tty_pkg::POS_W-1:0]          print_column,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tty_pkg::DELAY_W-1:0]   cfg_data
);

	logic             res_take;
	logic             res_load;
	tty_pkg::result_t res;
	tty_pkg::result_t res_s2;

	assign cfg_ready = 1'b1;

	tty_core #(
		.COLUMNS (COLUMNS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.iot_bits  (iot_bits),
		.ac_in     (ac_in),
		.key_code  (key_code),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_take  (res_take),
		.res_load  (res_load),
		.res       (res)
	);

	tty_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.res_take  (res_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign skip         = res_s2.skip;
	assign ac_written   = res_s2.ac_written;
	assign ac_out       = res_s2.ac_out;
	assign print_valid  = res_s2.print_valid;
	assign print_kind   = res_s2.print_kind;
	assign print_char   = res_s2.print_char;
	assign print_column = res_s2.print_column;

	// a result only moves into a free or draining result register
	`TTY_ASSERT_NOW(a_load_room, res_load, !out_valid || out_ready)
	`TTY_ASSERT_NEXT(a_load_shows, res_load, out_valid)
	// print events only come from ticks, never with iot outputs
	`TTY_ASSERT_NOW(a_print_alone, out_valid && print_valid, !skip && !ac_written)
	`TTY_ASSERT_NOW(a_col_range, out_valid && print_valid,
		print_column <= tty_pkg::POS_W'(COLUMNS - 1))
	`TTY_ASSERT_NOW(a_cr_home, out_valid && print_valid && print_kind == tty_pkg::PK_CR,
		print_column == '0)

endmodule

`default_nettype wire

FILE: sv/tty_core.sv
// ----------------------------------------------------------------------------
// tty_core
// input register, device state and the single-pass next-state logic
// ----------------------------------------------------------------------------
`default_nettype none

module tty_core #(
	parameter int COLUMNS = tty_pkg::COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    cmd,
	input  wire logic [2:0]                    iot_bits,
	input  wire logic [tty_pkg::AC_W-1:0]      ac_in,
	input  wire logic [tty_pkg::KEY_W-1:0]     key_code,
	input  wire logic                          cfg_valid,
	input  wire logic [tty_pkg::DELAY_W-1:0]   cfg_data,
	input  wire logic                          res_take,
	output logic                               res_load,
	output tty_pkg::result_t                   res
);

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);

	// input stage
	logic                           v_s1;
	tty_pkg::cmd_t                  cmd_s1;
	logic [2:0]                     bits_s1;
	logic [tty_pkg::AC_W-1:0]       ac_s1;
	logic [tty_pkg::KEY_W-1:0]      key_s1;

	// device state
	logic [tty_pkg::DELAY_W-1:0]    punch_delay_q;
	logic                           punch_flag_q, punch_flag_n;
	logic [tty_pkg::AC_W-1:0]       punch_buf_q, punch_buf_n;
	logic [tty_pkg::TIMER_W-1:0]    punch_timer_q, punch_timer_n;
	logic                           rd_flag_q, rd_flag_n;
	logic [tty_pkg::KEY_W-1:0]      rd_buf_q, rd_buf_n;
	logic [COL_W-1:0]               col_q, col_n;

	logic [tty_pkg::KEY_W-1:0]      rd_xl1, rd_xl2;
	logic [tty_pkg::TIMER_W-1:0]    timer_dec;

	assign res_load = v_s1 && res_take;
	assign in_ready = !v_s1 || res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= tty_pkg::cmd_t'(cmd);
			bits_s1 <= iot_bits;
			ac_s1   <= ac_in;
			key_s1  <= key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			punch_delay_q <= tty_pkg::DELAY_RST;
		end else if (cfg_valid) begin
			punch_delay_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			punch_flag_q  <= 1'b0;
			punch_buf_q   <= '0;
			punch_timer_q <= '0;
			rd_flag_q     <= 1'b0;
			rd_buf_q      <= '0;
			col_q         <= '0;
		end else if (res_load) begin
			punch_flag_q  <= punch_flag_n;
			punch_buf_q   <= punch_buf_n;
			punch_timer_q <= punch_timer_n;
			rd_flag_q     <= rd_flag_n;
			rd_buf_q      <= rd_buf_n;
			col_q         <= col_n;
		end
	end

	// reader translation, applied in sequence
	assign rd_xl1 = (rd_buf_q == tty_pkg::RD_LF_IN) ? tty_pkg::RD_CR_OUT : rd_buf_q;
	assign rd_xl2 = (rd_xl1 == tty_pkg::RD_ALT_IN) ? tty_pkg::RD_LF_OUT : rd_xl1;

	assign timer_dec = punch_timer_q - tty_pkg::TIMER_W'(1);

	always_comb begin
		punch_flag_n  = punch_flag_q;
		punch_buf_n   = punch_buf_q;
		punch_timer_n = punch_timer_q;
		rd_flag_n     = rd_flag_q;
		rd_buf_n      = rd_buf_q;
		col_n         = col_q;
		res           = '0;
		case (cmd_s1)
			tty_pkg::CMD_READER: begin
				res.skip = bits_s1[tty_pkg::IOT_SKIP] && rd_flag_q;
				if (bits_s1[tty_pkg::IOT_CLEAR]) begin
					rd_flag_n      = 1'b0;
					res.ac_written = 1'b1;
				end
				if (bits_s1[tty_pkg::IOT_XFER]) begin
					rd_buf_n       = rd_xl2;
					res.ac_written = 1'b1;
					res.ac_out     = tty_pkg::AC_W'(rd_xl2 | tty_pkg::RD_MARK);
				end
			end
			tty_pkg::CMD_PUNCH: begin
				res.skip = bits_s1[tty_pkg::IOT_SKIP] && punch_flag_q;
				if (bits_s1[tty_pkg::IOT_CLEAR]) begin
					punch_flag_n = 1'b0;
				end
				if (bits_s1[tty_pkg::IOT_XFER]) begin
					punch_buf_n   = ac_s1;
					punch_timer_n = tty_pkg::TIMER_W'(punch_delay_q) + tty_pkg::TIMER_W'(1);
				end
			end
			tty_pkg::CMD_KEY: begin
				rd_buf_n  = key_s1;
				rd_flag_n = 1'b1;
			end
			tty_pkg::CMD_TICK: begin
				if (punch_timer_q != '0) begin
					punch_timer_n = timer_dec;
					// last tick: the punch finishes and reports
					if (timer_dec == '0) begin
						punch_flag_n    = 1'b1;
						res.print_valid = 1'b1;
						if (punch_buf_q == tty_pkg::PC_CR) begin
							col_n            = '0;
							res.print_kind   = tty_pkg::PK_CR;
							res.print_column = '0;
						end else if (punch_buf_q == tty_pkg::PC_LF) begin
							res.print_kind   = tty_pkg::PK_LF;
							res.print_column = tty_pkg::POS_W'(col_q);
						end else if (punch_buf_q == tty_pkg::PC_BS) begin
							col_n            = (col_q != '0) ? col_q - COL_W'(1) : col_q;
							res.print_kind   = tty_pkg::PK_BS;
							res.print_column = tty_pkg::POS_W'(col_n);
						end else begin
							res.print_kind   = tty_pkg::PK_PRINT;
							res.print_char   = punch_buf_q[tty_pkg::CHAR_W-1:0];
							res.print_column = tty_pkg::POS_W'(col_q);
							col_n            = (col_q != COL_MAX) ? col_q + COL_W'(1) : col_q;
						end
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/tty_outreg.sv
// ----------------------------------------------------------------------------
// tty_outreg
// result register with valid and ready toward the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module tty_outreg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_load,
	input  wire tty_pkg::result_t  res,
	output logic                   res_take,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tty_pkg::result_t       res_s2
);

	logic out_valid_q;

	// free, or emptied by a transfer in this cycle
	assign res_take  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

FILE: tb/teletype_reader_punch_interface_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teletype_reader_punch_interface_test
// self-checking bench: streams reader and punch iots, key arrivals and ticks
// through randomly stalled handshakes, predicts every result from its own
// copy of the flags, buffers, timer and column, and checks each field
// ----------------------------------------------------------------------------
module teletype_reader_punch_interface_test;

	localparam int CLK_PERIOD    = 8;
	localparam int TTY_COLUMNS   = tty_pkg::COLUMNS_DEF;
	localparam int STALL_LIMIT   = 5000;
	localparam int ERR_PRINT_MAX = 40;
	localparam int RX_HOLD_LEN   = 300;

	typedef struct {
		tty_pkg::cmd_t             kind;
		logic [2:0]                bits;
		logic [tty_pkg::AC_W-1:0]  ac;
		logic [tty_pkg::KEY_W-1:0] key;
	} tty_item_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic [1:0]                   cmd        = '0;
	logic [2:0]                   iot_bits   = '0;
	logic [tty_pkg::AC_W-1:0]     ac_in      = '0;
	logic [tty_pkg::KEY_W-1:0]    key_code   = '0;
	logic                         out_ready  = 1'b0;
	logic                         cfg_valid  = 1'b0;
	logic [tty_pkg::DELAY_W-1:0]  cfg_data   = '0;
	logic                         in_ready;
	logic                         out_valid;
	logic                         skip;
	logic                         ac_written;
	logic [tty_pkg::AC_W-1:0]     ac_out;
	logic                         print_valid;
	logic [1:0]                   print_kind;
	logic [tty_pkg::CHAR_W-1:0]   print_char;
	logic [tty_pkg::POS_W-1:0]    print_column;
	logic                         cfg_ready;

	teletype_reader_punch_interface #(
		.COLUMNS(TTY_COLUMNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.iot_bits(iot_bits),
		.ac_in(ac_in),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.skip(skip),
		.ac_written(ac_written),
		.ac_out(ac_out),
		.print_valid(print_valid),
		.print_kind(print_kind),
		.print_char(print_char),
		.print_column(print_column),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted interface state, reset values
	logic [tty_pkg::DELAY_W-1:0] tty_delay = tty_pkg::DELAY_RST;
	logic                        pun_flag  = 1'b0;
	logic [tty_pkg::AC_W-1:0]    pun_buf   = '0;
	logic [tty_pkg::TIMER_W-1:0] pun_timer = '0;
	logic                        rdr_flag  = 1'b0;
	logic [tty_pkg::KEY_W-1:0]   rdr_buf   = '0;
	logic [tty_pkg::POS_W-1:0]   col       = '0;

	tty_item_t        items_pending[$];
	tty_pkg::result_t responses_due[$];
	tty_item_t        tx_item;
	tty_pkg::result_t want;

	int  errors          = 0;
	int  items_in        = 0;
	int  results_checked = 0;
	int  prints_seen     = 0;
	int  col_peak        = 0;
	int  settings_used   = 1;
	int  idle_pct        = 25;
	int  tx_gap          = 0;
	int  rx_gap          = 0;
	int  rx_hold         = 0;
	int  quiet_cycles    = 0;
	bit  rx_hold_req     = 1'b0;
	bit  in_took         = 1'b0;
	bit  tty_idle        = 1'b0;

	// one item applied to the predicted state, returns the expected result
	function automatic tty_pkg::result_t tty_respond(input tty_pkg::cmd_t kind,
			input logic [2:0] bits, input logic [tty_pkg::AC_W-1:0] ac,
			input logic [tty_pkg::KEY_W-1:0] key);
		tty_pkg::result_t r;
		r = '0;
		case (kind)
		tty_pkg::CMD_READER: begin
			// skip looks at the flag before this iot's clear
			if (bits[tty_pkg::IOT_SKIP] && rdr_flag)
				r.skip = 1'b1;
			if (bits[tty_pkg::IOT_CLEAR]) begin
				rdr_flag = 1'b0;
				r.ac_written = 1'b1;
				r.ac_out = '0;
			end
			if (bits[tty_pkg::IOT_XFER]) begin
				if (rdr_buf == tty_pkg::RD_LF_IN)
					rdr_buf = tty_pkg::RD_CR_OUT;
				if (rdr_buf == tty_pkg::RD_ALT_IN)
					rdr_buf = tty_pkg::RD_LF_OUT;
				r.ac_written = 1'b1;
				r.ac_out = tty_pkg::AC_W'(rdr_buf | tty_pkg::RD_MARK);
			end
		end
		tty_pkg::CMD_PUNCH: begin
			if (bits[tty_pkg::IOT_SKIP] && pun_flag)
				r.skip = 1'b1;
			if (bits[tty_pkg::IOT_CLEAR])
				pun_flag = 1'b0;
			if (bits[tty_pkg::IOT_XFER]) begin
				pun_buf = ac;
				pun_timer = tty_pkg::TIMER_W'(tty_delay) + tty_pkg::TIMER_W'(1);
			end
		end
		tty_pkg::CMD_KEY: begin
			rdr_buf = key;
			rdr_flag = 1'b1;
		end
		default: begin
			if (pun_timer != '0) begin
				pun_timer = pun_timer - tty_pkg::TIMER_W'(1);
				if (pun_timer == '0) begin
					pun_flag = 1'b1;
					r.print_valid = 1'b1;
					if (pun_buf == tty_pkg::PC_CR) begin
						col = '0;
						r.print_kind = tty_pkg::PK_CR;
					end else if (pun_buf == tty_pkg::PC_LF) begin
						r.print_kind = tty_pkg::PK_LF;
					end else if (pun_buf == tty_pkg::PC_BS) begin
						if (col != '0)
							col = col - tty_pkg::POS_W'(1);
						r.print_kind = tty_pkg::PK_BS;
					end else begin
						r.print_kind = tty_pkg::PK_PRINT;
						r.print_char = pun_buf[tty_pkg::CHAR_W-1:0];
					end
					r.print_column = col;
					if (r.print_kind == tty_pkg::PK_PRINT && int'(col) < TTY_COLUMNS - 1)
						col = col + tty_pkg::POS_W'(1);
				end
			end
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		errors++;
		if (errors <= ERR_PRINT_MAX)
			$display("result %0d: %s is %0h, expected %0h", results_checked, what, got,
				exp_val);
	endtask

	// input driver: holds payload until transfer, random gaps between items
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (items_pending.size() > 0) begin
				tx_item = items_pending.pop_front();
				cmd <= tx_item.kind;
				iot_bits <= tx_item.bits;
				ac_in <= tx_item.ac;
				key_code <= tx_item.key;
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < idle_pct)
					tx_gap = $urandom_range(1, 15);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold = RX_HOLD_LEN;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct / 3) begin
			rx_gap = $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// transfer monitor: predicts on input transfers, checks result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_took = 1'b1;
				items_in++;
				responses_due.push_back(tty_respond(tty_pkg::cmd_t'(cmd), iot_bits, ac_in,
					key_code));
			end
			if (out_valid && out_ready) begin
				results_checked++;
				if (responses_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", 16'd1, 16'd0);
				end else begin
					want = responses_due.pop_front();
					if (skip !== want.skip)
						report_mismatch("skip", 16'(skip), 16'(want.skip));
					if (ac_written !== want.ac_written)
						report_mismatch("ac_written", 16'(ac_written), 16'(want.ac_written));
					if (ac_out !== want.ac_out)
						report_mismatch("ac_out", 16'(ac_out), 16'(want.ac_out));
					if (print_valid !== want.print_valid)
						report_mismatch("print_valid", 16'(print_valid),
							16'(want.print_valid));
					if (print_kind !== want.print_kind)
						report_mismatch("print_kind", 16'(print_kind), 16'(want.print_kind));
					if (print_char !== want.print_char)
						report_mismatch("print_char", 16'(print_char), 16'(want.print_char));
					if (print_column !== want.print_column)
						report_mismatch("print_column", 16'(print_column),
							16'(want.print_column));
					if (want.print_valid) begin
						prints_seen++;
						if (int'(want.print_column) > col_peak)
							col_peak = int'(want.print_column);
					end
				end
			end
		end
		tty_idle = items_pending.size() == 0 && !in_valid && responses_due.size() == 0;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
						quiet_cycles, responses_due.size());
					$display("teletype_reader_punch_interface_test: errors");
					$finish;
				end
			end
		end
	end

	task automatic queue_item(input tty_pkg::cmd_t kind, input int bits, input int ac,
			input int key);
		tty_item_t it;
		it.kind = kind;
		it.bits = 3'(bits);
		it.ac = tty_pkg::AC_W'(ac);
		it.key = tty_pkg::KEY_W'(key);
		items_pending.push_back(it);
	endtask

	// ticks carry random don't-care fields
	task automatic queue_ticks(input int n);
		repeat (n)
			queue_item(tty_pkg::CMD_TICK, $urandom, $urandom, $urandom);
	endtask

	function automatic int pick_punch_code(input int cr_odds);
		int r;
		r = $urandom_range(0, 99);
		if (r < cr_odds)
			return int'(tty_pkg::PC_CR);
		if (r < cr_odds + 8)
			return int'(tty_pkg::PC_LF);
		if (r < cr_odds + 16)
			return int'(tty_pkg::PC_BS);
		// carriage return pattern with high bits set prints
		if (r < cr_odds + 20)
			return int'(tty_pkg::PC_CR) | int'($urandom_range(1, 15) << 8);
		return int'($urandom_range(0, 4095));
	endfunction

	// mostly print jobs and key/read pairs, the rest loose items
	task automatic queue_random_items(input int n, input int cr_odds, input int print_share);
		int made;
		int sel;
		int ticks;
		int k;
		made = 0;
		while (made < n) begin
			sel = $urandom_range(0, 9);
			if (sel < print_share) begin
				queue_item(tty_pkg::CMD_PUNCH, 4 | $urandom_range(0, 3),
					pick_punch_code(cr_odds), $urandom);
				// now and then cut the wait short or let it run over; sometimes add a punch skip or clear
				ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int'(tty_delay) + 2)
					: int'(tty_delay) + 1;
				queue_ticks(ticks);
				made += 1 + ticks;
				if ($urandom_range(0, 1)) begin
					queue_item(tty_pkg::CMD_PUNCH, $urandom_range(0, 3), $urandom, $urandom);
					made++;
				end
			end else if (sel < print_share + 3) begin
				k = $urandom_range(0, 3);
				queue_item(tty_pkg::CMD_KEY, $urandom, $urandom,
					k == 0 ? int'(tty_pkg::RD_LF_IN) : k == 1 ? int'(tty_pkg::RD_ALT_IN)
					: int'($urandom));
				queue_item(tty_pkg::CMD_READER, $urandom_range(0, 7), $urandom, $urandom);
				made += 2;
				if ($urandom_range(0, 2) == 0) begin
					queue_item(tty_pkg::CMD_READER, $urandom_range(0, 7), $urandom, $urandom);
					made++;
				end
			end else begin
				queue_item(tty_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom);
				made++;
			end
		end
	endtask

	task automatic wait_idle;
		do
			@(negedge clk);
		while (!tty_idle);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_punch_delay(input logic [tty_pkg::DELAY_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tty_delay = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	int delays[5];

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reader corners and a restarted print at the reset delay
		queue_item(tty_pkg::CMD_TICK, 7, 4095, 511);
		queue_item(tty_pkg::CMD_READER, 1, 4095, 511);
		queue_item(tty_pkg::CMD_READER, 4, 0, 0);
		queue_item(tty_pkg::CMD_KEY, 0, 0, int'(tty_pkg::RD_LF_IN));
		queue_item(tty_pkg::CMD_READER, 7, 0, 0);
		queue_item(tty_pkg::CMD_READER, 5, 0, 0);
		queue_item(tty_pkg::CMD_KEY, 0, 0, 511);
		queue_item(tty_pkg::CMD_KEY, 0, 0, int'(tty_pkg::RD_ALT_IN));
		queue_item(tty_pkg::CMD_READER, 4, 0, 0);
		queue_item(tty_pkg::CMD_READER, 6, 0, 0);
		queue_item(tty_pkg::CMD_KEY, 0, 0, 0);
		queue_item(tty_pkg::CMD_READER, 2, 0, 0);
		queue_item(tty_pkg::CMD_PUNCH, 1, 0, 0);
		queue_item(tty_pkg::CMD_PUNCH, 4, 'o101, 0);
		queue_ticks(50);
		queue_item(tty_pkg::CMD_PUNCH, 4, int'(tty_pkg::PC_BS), 0);
		queue_ticks(int'(tty_pkg::DELAY_RST) + 1);
		queue_item(tty_pkg::CMD_PUNCH, 3, 0, 0);
		queue_item(tty_pkg::CMD_PUNCH, 1, 0, 0);
		wait_idle();

		// shortest delay: every print kind, print bit leaves the flag alone
		write_punch_delay('0);
		queue_item(tty_pkg::CMD_PUNCH, 4, 4095, 0);
		queue_ticks(1);
		queue_item(tty_pkg::CMD_PUNCH, 5, int'(tty_pkg::PC_LF), 0);
		queue_ticks(1);
		queue_item(tty_pkg::CMD_PUNCH, 4, int'(tty_pkg::PC_CR), 0);
		queue_ticks(1);
		queue_item(tty_pkg::CMD_PUNCH, 4, int'(tty_pkg::PC_BS), 0);
		queue_ticks(1);
		queue_item(tty_pkg::CMD_PUNCH, 6, int'(tty_pkg::PC_CR) | 'o4000, 0);
		queue_ticks(1);
		queue_item(tty_pkg::CMD_PUNCH, 4, 0, 0);
		queue_ticks(2);
		queue_item(tty_pkg::CMD_PUNCH, 1, 0, 0);
		wait_idle();

		// longest delay loads the timer's top bit; later print jobs restart it
		write_punch_delay('1);
		queue_item(tty_pkg::CMD_PUNCH, 4, 'o132, 0);
		queue_ticks(20);
		queue_item(tty_pkg::CMD_PUNCH, 1, 0, 0);
		wait_idle();

		delays = '{1, 5, 3, 2, 0};
		delays[2] = $urandom_range(2, 9);
		foreach (delays[p]) begin
			write_punch_delay(tty_pkg::DELAY_W'(delays[p]));
			if (p == 4) begin
				// no idling, no carriage returns: drive the column to its limit
				idle_pct = 0;
				queue_random_items(700, 0, 8);
			end else begin
				idle_pct = 30;
				queue_random_items(200, 6, 4);
			end
			if (p == 0)
				rx_hold_req = 1'b1;
			wait_idle();
		end

		repeat (8) @(negedge clk);
		errors += responses_due.size();
		$display("run covered %0d items over %0d punch delay settings, %0d results checked",
			items_in, settings_used, results_checked);
		$display("%0d print events, furthest column %0d, %0d mismatches",
			prints_seen, col_peak, errors);
		if (errors == 0) begin
			$display("teletype_reader_punch_interface_test: clean");
		end else begin
			$display("teletype_reader_punch_interface_test: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/tty_pkg.sv
sv/tty_core.sv
sv/tty_outreg.sv
sv/teletype_reader_punch_interface.sv
tb/teletype_reader_punch_interface_test.sv
